>>> hdl/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// Used by every module of the block except mhpq_ram; depends on nothing.
package mhpq_pkg;

	localparam int HEAP_DEPTH = 32;
	localparam int KEY_WIDTH  = 32;
	localparam int KEY_IN_W   = 32;
	localparam int COUNT_OUT_W = 6;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int CHILD_W    = ADDR_W + 2;
	localparam int IN_TDATA_W  = ((KEY_IN_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = KEY_IN_W + COUNT_OUT_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_EX_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic ins_go;
		logic ext_go;
		logic rd_parent;
		logic rd_root_last;
		logic rd_children;
		logic wr_key;
		logic up_move;
		logic dn_move;
		logic ex_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic idx_zero;
		logic parent_larger;
		logic leaf;
		logic child_smaller;
		logic count_zero;
		logic out_free;
	} stat_t;

endpackage

>>> hdl/min_heap_priority_queue.sv
// Binary min-heap priority queue of 32-bit signed keys, 32 entries, one item at a time.
// An insert climbs one level per step until its key settles; an extract moves the last key to
// the root and sifts it down one level per step until it settles, unless that empties the heap;
// a refused item (insert when full, extract when empty) only reports its status.
// The result is offered in the cycle the next item can be taken; a result not yet taken
// stalls the next item in its last cycle. Reset (arst_n, asynchronous) empties the heap and drops any waiting result.
module min_heap_priority_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mhpq_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] key
	input  logic                                s_tuser,  // [0] func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mhpq_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [31:0] min_key, [37:32] entry_count
	output logic [1:0]                          m_tuser   // [1:0] status
);

	mhpq_pkg::cmd_t  cmd;
	mhpq_pkg::stat_t stat;

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mhpq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_func    (s_tuser),
		.in_key     (s_tdata[mhpq_pkg::KEY_IN_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

>>> hdl/mhpq_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// Self-contained; no package dependency.
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> hdl/mhpq_ctrl.sv
// Sequencing state machine for insert (sift up) and extract (sift down).
// Depends on mhpq_pkg; drives the datapath through cmd_t and reads stat_t.
module mhpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	output logic            in_ready,
	input  mhpq_pkg::stat_t stat,
	output mhpq_pkg::cmd_t  cmd
);

	mhpq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_func == mhpq_pkg::FUNC_INSERT) begin
						if (stat.full) begin
							state_d = mhpq_pkg::S_DONE;
						end else begin
							cmd.ins_go = 1'b1;
							state_d    = mhpq_pkg::S_UP_RD;
						end
					end else begin
						if (stat.empty) begin
							state_d = mhpq_pkg::S_DONE;
						end else begin
							cmd.ext_go       = 1'b1;
							cmd.rd_root_last = 1'b1;
							state_d          = mhpq_pkg::S_EX_LOAD;
						end
					end
				end
			end
			mhpq_pkg::S_UP_RD: begin
				if (stat.idx_zero) begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_DONE;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = mhpq_pkg::S_UP_CMP;
				end
			end
			mhpq_pkg::S_UP_CMP: begin
				if (stat.parent_larger) begin
					cmd.up_move = 1'b1;
					state_d     = mhpq_pkg::S_UP_RD;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_DONE;
				end
			end
			mhpq_pkg::S_EX_LOAD: begin
				cmd.ex_load = 1'b1;
				state_d     = stat.count_zero ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_RD;
			end
			mhpq_pkg::S_DN_RD: begin
				if (stat.leaf) begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_DONE;
				end else begin
					cmd.rd_children = 1'b1;
					state_d         = mhpq_pkg::S_DN_CMP;
				end
			end
			mhpq_pkg::S_DN_CMP: begin
				if (stat.child_smaller) begin
					cmd.dn_move = 1'b1;
					state_d     = mhpq_pkg::S_DN_RD;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_DONE;
				end
			end
			mhpq_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mhpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// A sift step always follows a read issued in the cycle before.
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.up_move || cmd.dn_move) |-> $past(cmd.rd_parent || cmd.rd_children))
		else $error("sift step without a preceding read");

	// An item is only taken while no earlier item is being worked on.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !cmd.take)
		else $error("two items taken in consecutive cycles");

	// The result register is loaded exactly once per item, on leaving DONE.
	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == mhpq_pkg::S_IDLE)
		else $error("result loaded without returning to idle");
`endif

endmodule

>>> hdl/mhpq_datapath.sv
// Heap store, moving-key and index registers, comparators and result register.
// Depends on mhpq_pkg and mhpq_ram; controlled by mhpq_ctrl via cmd_t.
module mhpq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_func,
	input  logic [mhpq_pkg::KEY_IN_W-1:0]       in_key,
	input  mhpq_pkg::cmd_t                      cmd,
	output mhpq_pkg::stat_t                     stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mhpq_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic [1:0]                          out_status
);

	localparam int AW = mhpq_pkg::ADDR_W;
	localparam int CW = mhpq_pkg::CNT_W;
	localparam int KW = mhpq_pkg::KEY_WIDTH;
	localparam int XW = mhpq_pkg::CHILD_W;

	logic [CW-1:0]          count_q;
	logic [AW-1:0]          idx_q;
	logic signed [KW-1:0]   key_q;
	logic [KW-1:0]          min_q;
	mhpq_pkg::status_t      status_q;

	logic                                    out_valid_q;
	logic [mhpq_pkg::KEY_IN_W-1:0]           out_key_q;
	logic [mhpq_pkg::COUNT_OUT_W-1:0]        out_count_q;
	mhpq_pkg::status_t                       out_status_q;

	logic              ram_we;
	logic [AW-1:0]     ram_raddr_a, ram_raddr_b;
	logic [KW-1:0]     ram_wdata, rd_a, rd_b;
	logic [AW-1:0]     parent_idx;
	logic [XW-1:0]     left_w, right_w, count_w;
	logic              left_smaller, right_smaller;
	logic [KW-1:0]     small_val;
	logic [AW-1:0]     small_idx;

	assign parent_idx = AW'((idx_q - AW'(1)) >> 1);
	assign left_w     = XW'({idx_q, 1'b1});
	assign right_w    = left_w + XW'(1);
	assign count_w    = XW'(count_q);

	// Left child wins a tie with the right one; a child must be strictly smaller.
	always_comb begin
		left_smaller  = $signed(rd_a) < key_q;
		small_val     = left_smaller ? rd_a : key_q;
		right_smaller = (right_w < count_w) && ($signed(rd_b) < $signed(small_val));
		small_idx     = right_smaller ? right_w[AW-1:0] : left_w[AW-1:0];
		if (right_smaller) begin
			small_val = rd_b;
		end
	end

	always_comb begin
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		if (cmd.rd_parent) begin
			ram_raddr_a = parent_idx;
		end else if (cmd.rd_root_last) begin
			ram_raddr_b = AW'(count_q - CW'(1));
		end else if (cmd.rd_children) begin
			ram_raddr_a = left_w[AW-1:0];
			ram_raddr_b = right_w[AW-1:0];
		end
	end

	assign ram_we    = cmd.wr_key || cmd.up_move || cmd.dn_move;
	assign ram_wdata = cmd.wr_key ? key_q : (cmd.up_move ? rd_a : small_val);

	mhpq_ram #(
		.WIDTH(KW),
		.DEPTH(mhpq_pkg::HEAP_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (idx_q),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_go) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.ext_go) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			min_q <= '0;
			if (in_func == mhpq_pkg::FUNC_INSERT && stat.full) begin
				status_q <= mhpq_pkg::STATUS_FULL;
			end else if (in_func == mhpq_pkg::FUNC_EXTRACT && stat.empty) begin
				status_q <= mhpq_pkg::STATUS_EMPTY;
			end else begin
				status_q <= mhpq_pkg::STATUS_OK;
			end
		end
		if (cmd.ins_go) begin
			key_q <= KW'($signed(in_key));
			idx_q <= count_q[AW-1:0];
		end else if (cmd.ex_load) begin
			min_q <= rd_a;
			key_q <= $signed(rd_b);
			idx_q <= '0;
		end else if (cmd.up_move) begin
			idx_q <= parent_idx;
		end else if (cmd.dn_move) begin
			idx_q <= small_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_key_q    <= mhpq_pkg::KEY_IN_W'(min_q);
			out_count_q  <= mhpq_pkg::COUNT_OUT_W'(count_q);
			out_status_q <= status_q;
		end
	end

	assign stat.full          = count_q >= CW'(mhpq_pkg::HEAP_DEPTH);
	assign stat.empty         = count_q == '0;
	assign stat.idx_zero      = idx_q == '0;
	assign stat.parent_larger = key_q < $signed(rd_a);
	assign stat.leaf          = left_w >= count_w;
	assign stat.child_smaller = left_smaller || right_smaller;
	assign stat.count_zero    = count_q == '0;
	assign stat.out_free      = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_data   = mhpq_pkg::OUT_TDATA_W'({out_count_q, out_key_q});
	assign out_status = out_status_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(mhpq_pkg::HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	// Sifting up moves towards the root, sifting down away from it.
	a_up_dir: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_move |=> idx_q < $past(idx_q))
		else $error("sift up did not move towards the root");

	a_dn_dir: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_move |=> idx_q > $past(idx_q))
		else $error("sift down did not move away from the root");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("result register overwritten while held");
`endif

endmodule
